>>> hw/rtl/log_count_feature_hash_expander_assert.svh
`ifndef LOG_COUNT_FEATURE_HASH_EXPANDER_ASSERT_SVH
`define LOG_COUNT_FEATURE_HASH_EXPANDER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LCFHE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LCFHE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lcfhe_pkg.sv
`default_nettype none

package lcfhe_pkg;

   localparam logic [31:0] MIX_MUL = 32'd2654435761;
   localparam logic [31:0] MIX_ADD = 32'd2654435769;
   localparam int unsigned MIX_SHL = 6;
   localparam int unsigned MIX_SHR = 2;

   localparam int unsigned LIM_W   = 6;
   localparam int unsigned LVL_W   = 5;
   localparam int unsigned CNT_W   = 31;

   localparam logic [LIM_W-1:0] LIM_RESET = 6'd8;

   typedef enum logic {
      REG_MAX_LOG_LEVELS = 1'b0,
      REG_QUERY_MODE     = 1'b1
   } csr_reg_type;

   // One level issued by the sequencer into the hash pipeline.
   typedef struct packed {
      logic [1:0]       tag;
      logic [LVL_W-1:0] lvl;
      logic [31:0]      fh;
      logic             last;
   } issue_type;

   // seed ^ (xterm + (seed << 6) + (seed >> 2)); xterm already holds x*MUL + ADD
   function automatic logic [31:0] mix_round(input logic [31:0] seed,
                                             input logic [31:0] xterm);
      logic [31:0] t;
      t = xterm + (seed << MIX_SHL) + (seed >> MIX_SHR);
      return seed ^ t;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/log_count_feature_hash_expander.sv
// Channel   Direction  Handshake                    Payload
// req       in         req_valid / req_ready        source_tag, feature_hash, feature_count
// rsp       out        rsp_valid / rsp_ready        combined_hash, last_of_run
// csr       in/out     APB (psel, penable, pready)  max_log_levels @0x0, query_mode @0x4
//
// A request issues n = min(bit length of the count, limit) levels; req_ready rises the cycle after
// the last one issues. Index mode drops a request with n = 0 at accept; query mode issues level 0
// for it, marked last. Index mode issues one hash per cycle unless rsp stalls; query mode steps
// the levels silently and issues the last one. An issue passes the issue register, then the
// multiply, round-two and round-three stages. A stall on rsp freezes the pipeline and every issue
// but not query-mode stepping. Reset (synchronous) clears valids, busy, query_mode; limit gets 8.
`default_nettype none
`include "log_count_feature_hash_expander_assert.svh"

module log_count_feature_hash_expander (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_source_tag,
   input  logic [31:0] req_feature_hash,
   input  logic [30:0] req_feature_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_combined_hash,
   output logic        rsp_last_of_run,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned LIM_W = lcfhe_pkg::LIM_W;
   localparam int unsigned LVL_W = lcfhe_pkg::LVL_W;
   localparam int unsigned CNT_W = lcfhe_pkg::CNT_W;

   // configuration
   logic [LIM_W-1:0] lim_cfg_ff, lim_cfg_in;
   logic             query_cfg_ff, query_cfg_in;
   logic             csr_wr;
   lcfhe_pkg::csr_reg_type csr_sel;

   // sequencer
   logic             busy_ff, busy_in;
   logic [1:0]       tag_ff, tag_in;
   logic [31:0]      fh_ff, fh_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic [LIM_W-1:0] lim_ff, lim_in;
   logic             q_ff, q_in;
   logic             accept, adv, more, issue, issue_last, step;
   logic [LIM_W-1:0] lvl_inc;
   lcfhe_pkg::issue_type issue_bus;

   // pipeline
   logic                 p0_v_ff, p0_v_in;
   lcfhe_pkg::issue_type p0_ff, p0_in;
   logic                 p1_v_ff, p1_v_in;
   logic [31:0]          p1_s1_ff, p1_s1_in;
   logic [31:0]          p1_cm_ff, p1_cm_in;
   logic [31:0]          p1_fm_ff, p1_fm_in;
   logic                 p1_last_ff, p1_last_in;
   logic                 p2_v_ff, p2_v_in;
   logic [31:0]          p2_s2_ff, p2_s2_in;
   logic [31:0]          p2_fm_ff, p2_fm_in;
   logic                 p2_last_ff, p2_last_in;
   logic                 out_v_ff, out_v_in;
   logic [31:0]          out_hash_ff, out_hash_in;
   logic                 out_last_ff, out_last_in;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_sel    = lcfhe_pkg::csr_reg_type'(csr_paddr[2]);

   always_comb begin
      lim_cfg_in   = lim_cfg_ff;
      query_cfg_in = query_cfg_ff;
      csr_prdata   = '0;
      unique case (csr_sel)
         lcfhe_pkg::REG_MAX_LOG_LEVELS: begin
            csr_prdata = {{(32-LIM_W){1'b0}}, lim_cfg_ff};
            if (csr_wr) begin
               lim_cfg_in = csr_pwdata[LIM_W-1:0];
            end
         end
         lcfhe_pkg::REG_QUERY_MODE: begin
            csr_prdata = {31'd0, query_cfg_ff};
            if (csr_wr) begin
               query_cfg_in = csr_pwdata[0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ---------------- level sequencer ----------------
   assign adv       = ~out_v_ff | rsp_ready;
   assign req_ready = ~busy_ff;
   assign accept    = req_valid & req_ready;
   assign lvl_inc   = {{(LIM_W-LVL_W){1'b0}}, lvl_ff} + LIM_W'(1);

   always_comb begin
      more       = (|cnt_ff[CNT_W-1:1]) && (lvl_inc < lim_ff);
      issue_last = ~more;
      // query mode walks the levels without emitting until the last one
      step       = busy_ff & q_ff & more;
      issue      = busy_ff & adv & issue_last;
      if (!q_ff) begin
         issue = busy_ff & adv;
      end

      busy_in = busy_ff;
      tag_in  = tag_ff;
      fh_in   = fh_ff;
      cnt_in  = cnt_ff;
      lvl_in  = lvl_ff;
      lim_in  = lim_ff;
      q_in    = q_ff;
      if (accept) begin
         tag_in  = req_source_tag;
         fh_in   = req_feature_hash;
         cnt_in  = req_feature_count;
         lvl_in  = '0;
         lim_in  = lim_cfg_ff;
         q_in    = query_cfg_ff;
         // index mode with nothing to expand: drop the request
         busy_in = query_cfg_ff | ((|req_feature_count) & (|lim_cfg_ff));
      end else if (issue && issue_last) begin
         busy_in = 1'b0;
      end else if ((issue && !issue_last) || step) begin
         cnt_in = cnt_ff >> 1;
         lvl_in = lvl_inc[LVL_W-1:0];
      end

      issue_bus.tag  = tag_ff;
      issue_bus.lvl  = lvl_ff;
      issue_bus.fh   = fh_ff;
      issue_bus.last = issue_last;
   end

   // ---------------- hash pipeline ----------------
   always_comb begin
      p0_v_in  = p0_v_ff;
      p0_in    = p0_ff;
      p1_v_in  = p1_v_ff;
      p2_v_in  = p2_v_ff;
      out_v_in = out_v_ff;
      if (adv) begin
         p0_v_in  = issue;
         p0_in    = issue_bus;
         p1_v_in  = p0_v_ff;
         p2_v_in  = p1_v_ff;
         out_v_in = p2_v_ff;
      end

      // first round from a zero seed reduces to tag*MUL + ADD
      p1_s1_in   = 32'(p0_ff.tag) * lcfhe_pkg::MIX_MUL + lcfhe_pkg::MIX_ADD;
      p1_cm_in   = 32'(p0_ff.lvl) * lcfhe_pkg::MIX_MUL + lcfhe_pkg::MIX_ADD;
      p1_fm_in   = p0_ff.fh * lcfhe_pkg::MIX_MUL + lcfhe_pkg::MIX_ADD;
      p1_last_in = p0_ff.last;

      p2_s2_in   = lcfhe_pkg::mix_round(p1_s1_ff, p1_cm_ff);
      p2_fm_in   = p1_fm_ff;
      p2_last_in = p1_last_ff;

      out_hash_in = lcfhe_pkg::mix_round(p2_s2_ff, p2_fm_ff);
      out_last_in = p2_last_ff;
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_combined_hash = out_hash_ff;
   assign rsp_last_of_run   = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_cfg_ff   <= lcfhe_pkg::LIM_RESET;
         query_cfg_ff <= 1'b0;
         busy_ff      <= 1'b0;
         p0_v_ff      <= 1'b0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         lim_cfg_ff   <= lim_cfg_in;
         query_cfg_ff <= query_cfg_in;
         busy_ff      <= busy_in;
         p0_v_ff      <= p0_v_in;
         p1_v_ff      <= p1_v_in;
         p2_v_ff      <= p2_v_in;
         out_v_ff     <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      fh_ff  <= fh_in;
      cnt_ff <= cnt_in;
      lvl_ff <= lvl_in;
      lim_ff <= lim_in;
      q_ff   <= q_in;
      p0_ff  <= p0_in;
      if (adv) begin
         p1_s1_ff    <= p1_s1_in;
         p1_cm_ff    <= p1_cm_in;
         p1_fm_ff    <= p1_fm_in;
         p1_last_ff  <= p1_last_in;
         p2_s2_ff    <= p2_s2_in;
         p2_fm_ff    <= p2_fm_in;
         p2_last_ff  <= p2_last_in;
         out_hash_ff <= out_hash_in;
         out_last_ff <= out_last_in;
      end
   end

   // ---------------- assertions ----------------
   `LCFHE_ASSERT_IMPL(a_query_single_issue, clock, reset, issue && q_ff, issue_last,
      "query mode issued a level not marked last")
   `LCFHE_ASSERT_NEXT(a_run_continues, clock, reset, issue && !issue_last, busy_ff,
      "sequencer went idle before the last level")
   `LCFHE_ASSERT_NEXT(a_stall_freezes_stage, clock, reset, !adv, $stable(p2_s2_ff),
      "round-two stage changed during a stall")

endmodule

`default_nettype wire
